FILE: src/pta_pkg.sv
package pta_pkg;

  // Field widths of the transaction payloads.
  localparam int SYM_W     = 64;
  localparam int SYM_BYTES = SYM_W / 8;
  localparam int PRICE_W   = 40;
  localparam int COUNT_W   = 7;

  // Operation codes.
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Direction codes.
  localparam logic DIR_ABOVE = 1'b0;
  localparam logic DIR_BELOW = 1'b1;

  // Status codes.
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One stored alert entry.
  typedef struct packed {
    logic               fired;
    logic               direction;
    logic [PRICE_W-1:0] threshold;
    logic [SYM_W-1:0]   symbol;
  } entry_t;

endpackage

FILE: src/pta_if.sv
// Request channel: one alert operation per transaction.
interface pta_in_if;
  import pta_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [SYM_W-1:0]   symbol;
  logic [PRICE_W-1:0] price_value;
  logic               direction;

  modport source (output valid, output opcode, output symbol, output price_value,
                  output direction, input ready);
  modport sink   (input valid, input opcode, input symbol, input price_value,
                  input direction, output ready);
endinterface

// Result channel: one result per request.
interface pta_out_if;
  import pta_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [COUNT_W-1:0] fired_count;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output fired_count, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input fired_count, input entry_count,
                  output ready);
endinterface

FILE: src/price_threshold_alert_table.sv
// Price threshold alert table. Holds up to TABLE_DEPTH one-shot alerts in a
// single-port-write, single-port-read memory. A create transaction appends an
// entry (or reports the table full) and then loads its result. A check
// transaction walks every stored entry through one shared symbol and price
// comparator, one entry per cycle; that pace is set by the single memory read
// port feeding the comparator. The block accepts one request at a time and is
// ready again as soon as the result register is loaded. A finished result
// sits in an output register, so the next request may be accepted while the
// result waits; a result that cannot be loaded because the previous one is
// still waiting holds the block until that one is taken. Symbols are folded
// to upper case and cut at the first zero byte before they are stored or
// compared. Counts on the result channel are the low seven bits.
module price_threshold_alert_table #(
  parameter int TABLE_DEPTH  = 64,
  parameter int SYMBOL_CHARS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  pta_in_if.sink   in_ch,
  pta_out_if.source out_ch
);
  import pta_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Keep the first SYMBOL_CHARS bytes up to the first zero byte, letters in upper case.
  function automatic logic [SYM_W-1:0] fold_symbol(input logic [SYM_W-1:0] raw);
    logic [SYM_W-1:0] folded;
    logic             live;
    logic [7:0]       ch;
    folded = '0;
    live   = 1'b1;
    for (int pos = 0; pos < SYM_BYTES; pos++) begin
      ch = raw[8*pos +: 8];
      if (pos >= SYMBOL_CHARS || ch == 8'h00) live = 1'b0;
      if (live) begin
        if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'h20;
        folded[8*pos +: 8] = ch;
      end
    end
    return folded;
  endfunction

  state_t             state_r;
  logic [SYM_W-1:0]   sym_r;
  logic [PRICE_W-1:0] price_r;
  logic               op_r;
  logic               full_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   scan_idx_r;
  logic [CNT_W-1:0]   fired_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   cmp_addr_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [COUNT_W-1:0] out_fired_r;
  logic [COUNT_W-1:0] out_entries_r;

  entry_t             mem_r [TABLE_DEPTH];
  entry_t             rd_data_r;

  logic               in_acc;
  logic               full;
  logic               issue;
  logic [IDX_W-1:0]   rd_addr;
  logic               price_hit;
  logic               hit;
  logic               out_free;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [CNT_W+COUNT_W-1:0] fired_ext;

  // Handshake and sequencing conditions.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);
  assign full        = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign issue       = (state_r == ST_SCAN) && (scan_idx_r < cnt_r);
  assign rd_addr     = scan_idx_r[IDX_W-1:0];
  assign out_free    = !out_valid_r || out_ch.ready;

  // The shared comparator: one entry read back from memory per cycle.
  assign price_hit = (rd_data_r.direction == DIR_BELOW) ? (price_r <= rd_data_r.threshold)
                                                        : (price_r >= rd_data_r.threshold);
  assign hit       = rd_vld_r && !rd_data_r.fired && (rd_data_r.symbol == sym_r) && price_hit;

  // Memory write: a new entry on create, or the fired mark during a scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[IDX_W-1:0];
    wr_data = '{fired: 1'b0, direction: in_ch.direction, threshold: in_ch.price_value,
                symbol: fold_symbol(in_ch.symbol)};
    if (hit) begin
      wr_en         = 1'b1;
      wr_addr       = cmp_addr_r;
      wr_data       = rd_data_r;
      wr_data.fired = 1'b1;
    end else if (in_acc && in_ch.opcode == OP_CREATE && !full) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  // Counts are reported as their low seven bits.
  assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_r};
  assign fired_ext = {{COUNT_W{1'b0}}, fired_r};

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r   <= issue;
      cmp_addr_r <= rd_addr;
      if (out_ch.ready && state_r != ST_FINISH) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sym_r      <= fold_symbol(in_ch.symbol);
            price_r    <= in_ch.price_value;
            op_r       <= in_ch.opcode;
            full_r     <= full;
            scan_idx_r <= '0;
            fired_r    <= '0;
            if (in_ch.opcode == OP_CREATE && !full) cnt_r <= cnt_r + 1'b1;
            state_r <= (in_ch.opcode == OP_CHECK) ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (issue) scan_idx_r <= scan_idx_r + 1'b1;
          if (hit) fired_r <= fired_r + 1'b1;
          if (!issue && !rd_vld_r) state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= (op_r == OP_CREATE && full_r) ? STATUS_FULL : STATUS_GOOD;
            out_fired_r   <= fired_ext[COUNT_W-1:0];
            out_entries_r <= cnt_ext[COUNT_W-1:0];
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.fired_count = out_fired_r;
  assign out_ch.entry_count = out_entries_r;

endmodule

FILE: src/pta_chk.sv
// Port-level checks for the alert table.
module pta_chk #(
  parameter int TABLE_DEPTH = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_status,
  input logic [pta_pkg::COUNT_W-1:0] out_fired_count,
  input logic [pta_pkg::COUNT_W-1:0] out_entry_count
);
  import pta_pkg::*;

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // Reset leaves no result on offer.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One request at a time: ready drops after an accepted transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in progress");

  // A full table reports no fired entries and the full entry count.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |->
      out_fired_count == '0 && out_entry_count == COUNT_W'(TABLE_DEPTH))
    else $error("table full result carries wrong counts");

endmodule

bind price_threshold_alert_table pta_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_pta_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_fired_count (out_ch.fired_count),
  .out_entry_count (out_ch.entry_count)
);
